@@ hdl/srbfq_pkg.sv @@
// Shared types, band plan table and frequency classifier for the spot ring
// band filter query block. No dependencies.
package srbfq_pkg;

    localparam int FREQ_W    = 30;
    localparam int WORD_W    = 32;
    localparam int LIMIT_W   = 7;
    localparam int MASK_W    = 13;
    localparam int BAND_W    = 4;
    localparam int MODE_W    = 2;
    localparam int PLAN_ROWS = 29;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [FREQ_W-1:0]   freq_hz;
        logic [WORD_W-1:0]   stamp;
        logic [WORD_W-1:0]   spotter_tag;
        logic [WORD_W-1:0]   dx_tag;
        logic [LIMIT_W-1:0]  limit;
        logic [MASK_W-1:0]   enable_mask;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]   out_stamp;
        logic [FREQ_W-1:0]   out_freq_hz;
        logic [WORD_W-1:0]   out_spotter_tag;
        logic [WORD_W-1:0]   out_dx_tag;
        logic                empty_res;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [WORD_W-1:0]   stamp;
        logic [WORD_W-1:0]   spotter;
        logic [WORD_W-1:0]   dx;
    } t_entry;

    typedef struct packed {
        logic                query;
        t_entry              entry;
        logic [LIMIT_W-1:0]  cap;
        logic [MASK_W-1:0]   mask;
    } t_cmd;

    typedef struct packed {
        logic [BAND_W-1:0]   band;
        logic [MODE_W-1:0]   mode;
        logic [FREQ_W-1:0]   lo;
        logic [FREQ_W-1:0]   hi;
    } t_plan_row;

    typedef struct packed {
        logic                hit;
        logic [BAND_W-1:0]   band;
        logic [MODE_W-1:0]   mode;
    } t_class;

    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        '{4'd8,  2'd1, 30'd1810000,  30'd1838000},
        '{4'd8,  2'd2, 30'd1838000,  30'd1843000},
        '{4'd8,  2'd0, 30'd1843000,  30'd2000000},
        '{4'd7,  2'd1, 30'd3500000,  30'd3570000},
        '{4'd7,  2'd2, 30'd3570000,  30'd3600000},
        '{4'd7,  2'd0, 30'd3600000,  30'd3800000},
        '{4'd6,  2'd1, 30'd7000000,  30'd7040000},
        '{4'd6,  2'd2, 30'd7040000,  30'd7080000},
        '{4'd6,  2'd0, 30'd7060000,  30'd7200000},
        '{4'd5,  2'd1, 30'd14000000, 30'd14070000},
        '{4'd5,  2'd2, 30'd14070000, 30'd14112000},
        '{4'd5,  2'd0, 30'd14112000, 30'd14350000},
        '{4'd4,  2'd1, 30'd21000000, 30'd21070000},
        '{4'd4,  2'd2, 30'd21070000, 30'd21151000},
        '{4'd4,  2'd0, 30'd21151000, 30'd21450000},
        '{4'd3,  2'd1, 30'd28000000, 30'd28070000},
        '{4'd3,  2'd2, 30'd28070000, 30'd28320000},
        '{4'd3,  2'd0, 30'd28320000, 30'd29700000},
        '{4'd11, 2'd1, 30'd10100000, 30'd10130000},
        '{4'd11, 2'd2, 30'd10130000, 30'd10150000},
        '{4'd10, 2'd1, 30'd18068000, 30'd18095000},
        '{4'd10, 2'd2, 30'd18095000, 30'd18111000},
        '{4'd10, 2'd0, 30'd18111000, 30'd18168000},
        '{4'd9,  2'd1, 30'd24890000, 30'd24915000},
        '{4'd9,  2'd2, 30'd24915000, 30'd24931000},
        '{4'd9,  2'd0, 30'd24931000, 30'd24990000},
        '{4'd12, 2'd1, 30'd5151500,  30'd5153000},
        '{4'd12, 2'd2, 30'd5154000,  30'd5366000},
        '{4'd12, 2'd0, 30'd5366000,  30'd5366500}
    };

    // First matching row wins: walk backward so earlier rows override.
    function automatic t_class srbfq_classify(input logic [FREQ_W-1:0] f);
        t_class c;
        c = '0;
        for (int i = PLAN_ROWS - 1; i >= 0; i--) begin
            if (f >= PLAN[i].lo && f <= PLAN[i].hi) begin
                c.hit  = 1'b1;
                c.band = PLAN[i].band;
                c.mode = PLAN[i].mode;
            end
        end
        return c;
    endfunction

endpackage

@@ hdl/srbfq_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
// Generic over the item type; no package dependency.
module srbfq_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_SLOT) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/srbfq_front.sv @@
// Front end: takes input transfers, decodes insert/query and saturates the
// limit, then queues commands for the back end. Uses srbfq_pkg, srbfq_fifo.
module srbfq_front #(
    parameter int MAX_RESULTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  srbfq_pkg::t_in_item i_item,
    output logic                full,
    input  logic                i_hold,
    output srbfq_pkg::t_cmd     o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_take
);
    import srbfq_pkg::*;

    localparam logic [LIMIT_W-1:0] CAP_MAX = LIMIT_W'(MAX_RESULTS);

    t_cmd cmd_in;
    logic q_full;
    logic q_empty;

    always_comb begin
        cmd_in.query         = (i_item.func == FUNC_QUERY);
        cmd_in.entry.freq    = i_item.freq_hz;
        cmd_in.entry.stamp   = i_item.stamp;
        cmd_in.entry.spotter = i_item.spotter_tag;
        cmd_in.entry.dx      = i_item.dx_tag;
        cmd_in.cap           = (i_item.limit > CAP_MAX) ? CAP_MAX : i_item.limit;
        cmd_in.mask          = i_item.enable_mask;
    end

    assign full        = q_full || i_hold;
    assign o_cmd_valid = !q_empty;

    srbfq_fifo #(
        .T     (t_cmd),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (i_cmd_take),
        .o_data  (o_cmd),
        .o_empty (q_empty)
    );

endmodule

@@ hdl/srbfq_back.sv @@
// Back end: ring memory of spots, clear pass, newest-first scan with band
// plan filter, and the result queue. Uses srbfq_pkg, srbfq_fifo.
module srbfq_back #(
    parameter int RING_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  srbfq_pkg::t_cmd      i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_take,
    output logic                 o_clearing,
    output srbfq_pkg::t_out_item o_result,
    output logic                 empty,
    input  logic                 pop
);
    import srbfq_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int LW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FLUSH} t_state;

    t_state             r_state;
    t_entry             r_mem [RING_DEPTH];
    t_entry             r_rd_data;
    t_entry             r_pend;
    logic               r_pend_valid;
    logic               r_dv;
    logic [AW-1:0]      r_wp;
    logic [AW-1:0]      r_ra;
    logic [AW-1:0]      r_clr_addr;
    logic [LW-1:0]      r_left;
    logic [LIMIT_W-1:0] r_cap;
    logic [LIMIT_W-1:0] r_cnt;
    logic [MASK_W-1:0]  r_mask;

    t_class     cls;
    logic       hit;
    logic       done_now;
    logic       stall;
    logic       rd_en;
    logic       res_full;
    logic       res_push;
    t_out_item  res_data;
    logic       do_insert;

    always_comb begin
        cls      = srbfq_classify(r_rd_data.freq);
        hit      = r_dv && (r_rd_data.freq != '0) && cls.hit
                   && r_mask[cls.band] && r_mask[BAND_W'(cls.mode)];
        done_now = hit && (LIMIT_W'(r_cnt + 1'b1) == r_cap);
        stall    = res_full;
        rd_en    = (r_state == S_SCAN) && !stall && !done_now && (r_left != '0);
        do_insert  = (r_state == S_IDLE) && i_cmd_valid && !i_cmd.query;
        o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
        o_clearing = (r_state == S_CLEAR);

        res_data.out_stamp       = r_pend.stamp;
        res_data.out_freq_hz     = r_pend.freq;
        res_data.out_spotter_tag = r_pend.spotter;
        res_data.out_dx_tag      = r_pend.dx;
        res_data.empty_res       = 1'b0;
        res_data.last            = 1'b0;
        res_push                 = 1'b0;
        case (r_state)
            S_SCAN: begin
                res_push = !stall && hit && r_pend_valid;
            end
            S_FLUSH: begin
                res_push      = !stall;
                res_data.last = 1'b1;
                if (!r_pend_valid) begin
                    res_data           = '0;
                    res_data.empty_res = 1'b1;
                    res_data.last      = 1'b1;
                end
            end
            default: res_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_clr_addr] <= '0;
        end else if (do_insert) begin
            r_mem[r_wp] <= i_cmd.entry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_wp         <= '0;
            r_ra         <= '0;
            r_left       <= '0;
            r_cap        <= '0;
            r_cnt        <= '0;
            r_mask       <= '0;
            r_dv         <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (!i_cmd.query) begin
                            r_wp <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
                        end else begin
                            r_cap        <= i_cmd.cap;
                            r_mask       <= i_cmd.mask;
                            r_ra         <= (r_wp == '0) ? LAST_ADDR : r_wp - 1'b1;
                            r_left       <= LW'(RING_DEPTH);
                            r_cnt        <= '0;
                            r_dv         <= 1'b0;
                            r_pend_valid <= 1'b0;
                            r_state      <= (i_cmd.cap == '0) ? S_FLUSH : S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        r_dv <= rd_en;
                        if (rd_en) begin
                            r_ra   <= (r_ra == '0) ? LAST_ADDR : r_ra - 1'b1;
                            r_left <= r_left - 1'b1;
                        end
                        if (hit) begin
                            r_pend       <= r_rd_data;
                            r_pend_valid <= 1'b1;
                            r_cnt        <= r_cnt + 1'b1;
                        end
                        if (done_now || r_left == '0) begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!stall) begin
                        r_dv         <= 1'b0;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    srbfq_fifo #(
        .T     (t_out_item),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

@@ hdl/spot_ring_band_filter_query.sv @@
// Channel  | Ports                       | Transfer when
// ---------+-----------------------------+---------------------
// input    | push, full, i_item          | push && !full
// result   | empty, pop, o_result        | pop && !empty
//
// An insert is written to the ring when the back end takes it; a query reads one
// ring entry per cycle from the single memory read port while the result queue
// has room, stops early when the limit is reached, and ends with a flush step.
// After reset a clearing pass zeroes the whole ring; full is held high until
// it ends. A full result queue stalls the scan in place.
// Top level; uses srbfq_pkg, srbfq_front, srbfq_back.
module spot_ring_band_filter_query #(
    parameter int RING_DEPTH  = 1024,
    parameter int MAX_RESULTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    input  srbfq_pkg::t_in_item  i_item,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output srbfq_pkg::t_out_item o_result
);
    import srbfq_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;
    logic clearing;

    srbfq_front #(
        .MAX_RESULTS (MAX_RESULTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .i_hold      (clearing),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    srbfq_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .o_clearing  (clearing),
        .o_result    (o_result),
        .empty       (empty),
        .pop         (pop)
    );

endmodule
